// File: src/gps_time_to_calendar_date_defines.svh
// ---------------------------------------------------------------------------
// gps_time_to_calendar_date_defines.svh
// Assertion macros for the GPS time to calendar date block.
// ---------------------------------------------------------------------------
`ifndef GPS_TIME_TO_CALENDAR_DATE_DEFINES_SVH
`define GPS_TIME_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GTCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GTCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gtcd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtcd_pkg
// Widths, constants, stage numbering and shared types of the GPS time to
// calendar date pipeline.
// ---------------------------------------------------------------------------
package gtcd_pkg;

  // field widths
  localparam int WEEK_W  = 14;
  localparam int TOW_W   = 30;
  localparam int LEAP_W  = 6;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int MILLI_W = 16;

  // internal widths
  localparam int JD_W  = 22;   // day number c
  localparam int DY_W  = 13;   // Julian year count d
  localparam int G_W   = 10;   // day in the March-based year, c - e
  localparam int F_W   = 4;    // month count f

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LEAP = 1'b0;     // word index of leap_seconds
  localparam logic [LEAP_W-1:0] LEAP_RESET = LEAP_W'(18);

  // time constants
  localparam int MS_PER_SEC    = 1000;
  localparam int MS_PER_MINUTE = 60000;
  localparam int MS_PER_HOUR   = 3600000;
  localparam int MS_PER_DAY    = 86400000;
  localparam int DAYS_PER_WEEK = 7;

  // Julian-day constants
  localparam int GPS_EPOCH_JD = 2444245;
  localparam int JD_OFFSET    = 1537;
  localparam int YEAR_OFFSET  = 4715;
  localparam int DIV_YEAR     = 7305;      // 20 * 365.25
  localparam int DIV_MONTH    = 306001;    // 10000 * 30.6001
  localparam int MONTH_SCALE  = 10000;
  // day count is taken biased by one day so the floor quotient stays >= 0
  localparam int C_BASE = GPS_EPOCH_JD + JD_OFFSET - 1;
  localparam int Y_BASE = 20 * C_BASE - 2442;

  // reciprocals, scaled by 2**RCP_SH, rounded down
  localparam int RCP_SH = 32;
  localparam longint RCP_DAY   = (64'd1 << RCP_SH) / MS_PER_DAY;
  localparam longint RCP_HOUR  = (64'd1 << RCP_SH) / MS_PER_HOUR;
  localparam longint RCP_MIN   = (64'd1 << RCP_SH) / MS_PER_MINUTE;
  localparam longint RCP_YEAR  = (64'd1 << RCP_SH) / DIV_YEAR;
  localparam longint RCP_MONTH = ((64'd1 << RCP_SH) / DIV_MONTH) * MONTH_SCALE;

  // pipeline stages: A..H in the core, then the output register
  localparam int NUM_STAGES = 9;
  localparam int ST_OUT     = NUM_STAGES - 1;

  // core result handed to the output stage
  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [MILLI_W-1:0] milli;
    logic [DY_W-1:0]    dy;
    logic [G_W-1:0]     g;
    logic [F_W-1:0]     f;
  } gtcd_res_t;

  // floor(30.6001 * f)
  function automatic logic [8:0] month_base(input logic [F_W-1:0] f);
    logic [8:0] b;
    unique case (f)
      4'd0:  b = 9'd0;
      4'd1:  b = 9'd30;
      4'd2:  b = 9'd61;
      4'd3:  b = 9'd91;
      4'd4:  b = 9'd122;
      4'd5:  b = 9'd153;
      4'd6:  b = 9'd183;
      4'd7:  b = 9'd214;
      4'd8:  b = 9'd244;
      4'd9:  b = 9'd275;
      4'd10: b = 9'd306;
      4'd11: b = 9'd336;
      4'd12: b = 9'd367;
      4'd13: b = 9'd397;
      4'd14: b = 9'd428;
      4'd15: b = 9'd459;
    endcase
    return b;
  endfunction

endpackage

// File: src/gtcd_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtcd_core
// Datapath stages A..H: leap correction, day split, time of day and the
// Julian-day year and month counts. Constant divisions use a reciprocal
// multiply in one stage and a single compare/subtract fix in the next.
// ---------------------------------------------------------------------------
module gtcd_core import gtcd_pkg::*; (
  input  logic                  clk,
  input  logic [NUM_STAGES-2:0] stage_en,
  input  logic [WEEK_W-1:0]     gps_week,
  input  logic [TOW_W-1:0]      tow_ms,
  input  logic [LEAP_W-1:0]     leap_seconds,
  output gtcd_res_t             res
);

  // stage A: biased ms count, base day number
  logic [30:0]     x_a_r, x_a_nxt;
  logic [JD_W-1:0] c_a_r, c_a_nxt;
  logic [25:0]     y_a_r, y_a_nxt;
  logic [15:0]     leap_ms;
  // stage B
  logic [30:0]     x_b_r;
  logic [JD_W-1:0] c_b_r;
  logic [25:0]     y_b_r;
  logic [3:0]      q0_b_r, q0_b_nxt;
  logic [36:0]     p_day;
  // stage C
  logic [26:0]     t_c_r, t_c_nxt;
  logic [JD_W-1:0] c_c_r, c_c_nxt;
  logic [25:0]     y_c_r, y_c_nxt;
  logic [31:0]     r_day;
  logic [3:0]      q_day;
  // stage D
  logic [26:0]     t_d_r;
  logic [JD_W-1:0] c_d_r;
  logic [25:0]     y_d_r;
  logic [HOUR_W-1:0] h0_d_r, h0_d_nxt;
  logic [DY_W-1:0] d0_d_r, d0_d_nxt;
  logic [37:0]     p_hour;
  logic [45:0]     p_year;
  // stage E
  logic [HOUR_W-1:0] hour_e_r, hour_e_nxt;
  logic [21:0]     rh_e_r, rh_e_nxt;
  logic [DY_W-1:0] d_e_r, d_e_nxt;
  logic [JD_W-1:0] c_e_r;
  logic [26:0]     r_hour;
  logic [25:0]     r_year;
  // stage F
  logic [HOUR_W-1:0] hour_f_r;
  logic [21:0]     rh_f_r;
  logic [DY_W-1:0] d_f_r;
  logic [MIN_W-1:0] m0_f_r, m0_f_nxt;
  logic [G_W-1:0]  g_f_r, g_f_nxt;
  logic [38:0]     p_min;
  logic [JD_W-1:0] e_f, g_full;
  // stage G
  logic [HOUR_W-1:0] hour_g_r;
  logic [DY_W-1:0] d_g_r;
  logic [G_W-1:0]  g_g_r;
  logic [MIN_W-1:0] min_g_r, min_g_nxt;
  logic [MILLI_W-1:0] ms_g_r, ms_g_nxt;
  logic [F_W-1:0]  f0_g_r, f0_g_nxt;
  logic [21:0]     r_min;
  logic [37:0]     p_month;
  // stage H
  logic [F_W-1:0]  f_h_r, f_h_nxt;
  logic [HOUR_W-1:0] hour_h_r;
  logic [MIN_W-1:0] min_h_r;
  logic [MILLI_W-1:0] ms_h_r;
  logic [DY_W-1:0] d_h_r;
  logic [G_W-1:0]  g_h_r;
  logic [23:0]     r_month;

  // ---- stage A
  always_comb begin
    leap_ms = 16'(leap_seconds) * 16'(MS_PER_SEC);
    x_a_nxt = 31'(tow_ms) + 31'(MS_PER_DAY) - 31'(leap_ms);
    c_a_nxt = 22'(gps_week) * 22'(DAYS_PER_WEEK) + 22'(C_BASE);
    y_a_nxt = 26'(gps_week) * 26'(20 * DAYS_PER_WEEK) + 26'(Y_BASE);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x_a_r <= x_a_nxt;
      c_a_r <= c_a_nxt;
      y_a_r <= y_a_nxt;
    end
  end

  // ---- stage B: day quotient estimate
  always_comb begin
    p_day    = 37'(x_a_r) * 37'(RCP_DAY);
    q0_b_nxt = p_day[RCP_SH+3:RCP_SH];
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      x_b_r  <= x_a_r;
      c_b_r  <= c_a_r;
      y_b_r  <= y_a_r;
      q0_b_r <= q0_b_nxt;
    end
  end

  // ---- stage C: fix day quotient, time of day
  always_comb begin
    r_day = 32'(x_b_r) - 32'(q0_b_r) * 32'(MS_PER_DAY);
    if (r_day >= 32'(MS_PER_DAY)) begin
      q_day   = q0_b_r + 4'd1;
      t_c_nxt = 27'(r_day - 32'(MS_PER_DAY));
    end else begin
      q_day   = q0_b_r;
      t_c_nxt = 27'(r_day);
    end
    c_c_nxt = c_b_r + 22'(q_day);
    y_c_nxt = y_b_r + 26'(q_day) * 26'd20;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      t_c_r <= t_c_nxt;
      c_c_r <= c_c_nxt;
      y_c_r <= y_c_nxt;
    end
  end

  // ---- stage D: hour and year estimates
  always_comb begin
    p_hour   = 38'(t_c_r) * 38'(RCP_HOUR);
    h0_d_nxt = p_hour[RCP_SH+HOUR_W-1:RCP_SH];
    p_year   = 46'(y_c_r) * 46'(RCP_YEAR);
    d0_d_nxt = p_year[RCP_SH+DY_W-1:RCP_SH];
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      t_d_r  <= t_c_r;
      c_d_r  <= c_c_r;
      y_d_r  <= y_c_r;
      h0_d_r <= h0_d_nxt;
      d0_d_r <= d0_d_nxt;
    end
  end

  // ---- stage E: fix hour and year
  always_comb begin
    r_hour = t_d_r - 27'(h0_d_r) * 27'(MS_PER_HOUR);
    if (r_hour >= 27'(MS_PER_HOUR)) begin
      hour_e_nxt = h0_d_r + 5'd1;
      rh_e_nxt   = 22'(r_hour - 27'(MS_PER_HOUR));
    end else begin
      hour_e_nxt = h0_d_r;
      rh_e_nxt   = 22'(r_hour);
    end
    r_year  = y_d_r - 26'(d0_d_r) * 26'(DIV_YEAR);
    d_e_nxt = (r_year >= 26'(DIV_YEAR)) ? d0_d_r + 13'd1 : d0_d_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      hour_e_r <= hour_e_nxt;
      rh_e_r   <= rh_e_nxt;
      d_e_r    <= d_e_nxt;
      c_e_r    <= c_d_r;
    end
  end

  // ---- stage F: minute estimate, e = floor(365.25 d), g = c - e
  always_comb begin
    p_min    = 39'(rh_e_r) * 39'(RCP_MIN);
    m0_f_nxt = p_min[RCP_SH+MIN_W-1:RCP_SH];
    e_f      = 22'(d_e_r) * 22'd365 + 22'(d_e_r >> 2);
    g_full   = c_e_r - e_f;
    g_f_nxt  = g_full[G_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      hour_f_r <= hour_e_r;
      rh_f_r   <= rh_e_r;
      d_f_r    <= d_e_r;
      m0_f_r   <= m0_f_nxt;
      g_f_r    <= g_f_nxt;
    end
  end

  // ---- stage G: fix minute, month estimate
  always_comb begin
    r_min = rh_f_r - 22'(m0_f_r) * 22'(MS_PER_MINUTE);
    if (r_min >= 22'(MS_PER_MINUTE)) begin
      min_g_nxt = m0_f_r + 6'd1;
      ms_g_nxt  = 16'(r_min - 22'(MS_PER_MINUTE));
    end else begin
      min_g_nxt = m0_f_r;
      ms_g_nxt  = 16'(r_min);
    end
    p_month  = 38'(g_f_r) * 38'(RCP_MONTH);
    f0_g_nxt = p_month[RCP_SH+F_W-1:RCP_SH];
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      hour_g_r <= hour_f_r;
      d_g_r    <= d_f_r;
      g_g_r    <= g_f_r;
      min_g_r  <= min_g_nxt;
      ms_g_r   <= ms_g_nxt;
      f0_g_r   <= f0_g_nxt;
    end
  end

  // ---- stage H: fix month count
  always_comb begin
    r_month = 24'(g_g_r) * 24'(MONTH_SCALE) - 24'(f0_g_r) * 24'(DIV_MONTH);
    f_h_nxt = (r_month >= 24'(DIV_MONTH)) ? f0_g_r + 4'd1 : f0_g_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      f_h_r    <= f_h_nxt;
      hour_h_r <= hour_g_r;
      min_h_r  <= min_g_r;
      ms_h_r   <= ms_g_r;
      d_h_r    <= d_g_r;
      g_h_r    <= g_g_r;
    end
  end

  assign res = '{hour: hour_h_r, minute: min_h_r, milli: ms_h_r,
                 dy: d_h_r, g: g_h_r, f: f_h_r};

endmodule

// File: src/gps_time_to_calendar_date.sv
`timescale 1ns / 1ps
`include "gps_time_to_calendar_date_defines.svh"
// ---------------------------------------------------------------------------
// gps_time_to_calendar_date
// GPS week / time of week to UTC date and time, fully pipelined.
//
//   channel  | handshake          | word
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_stall  | gps_week, tow_ms
//   out      | out_valid/out_stall| year, month, day, hour, minute,
//            |                    | milli_of_minute
//   cfg      | APB (psel..pready) | leap_seconds at byte address 0
//
// One word per cycle while out_stall is low; each word passes through the nine
// register stages (eight in gtcd_core, one output register here).
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles are squeezed out under back-pressure.
// in_stall rises only when all nine stages hold words and out_stall is high.
// rst_n (synchronous) clears the valid bits and sets leap_seconds to 18.
// ---------------------------------------------------------------------------
module gps_time_to_calendar_date import gtcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input words
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WEEK_W-1:0]   in_gps_week,
  input  logic [TOW_W-1:0]    in_tow_ms,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output logic [YEAR_W-1:0]   out_year,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic [HOUR_W-1:0]   out_hour,
  output logic [MIN_W-1:0]    out_minute,
  output logic [MILLI_W-1:0]  out_milli_of_minute,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // leap second register
  logic [LEAP_W-1:0] leap_r, leap_nxt;
  logic              cfg_wr;

  // stage valid bits and load enables
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES-1:0] rdy;

  gtcd_res_t res;

  // output register
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   minute_r;
  logic [MILLI_W-1:0] milli_r;
  logic [G_W-1:0]     day_full;

  // ---- configuration: only word 0 exists, other words read zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LEAP);

  always_comb begin
    leap_nxt = cfg_wr ? pwdata[LEAP_W-1:0] : leap_r;
    prdata   = (paddr[2] == REG_LEAP) ? PDATA_W'(leap_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= LEAP_RESET;
    end else begin
      leap_r <= leap_nxt;
    end
  end

  // ---- pipeline control: a stage loads when empty or when its word leaves
  always_comb begin
    rdy[ST_OUT] = !vld_r[ST_OUT] || !out_stall;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rdy[0];

  // ---- stages A..H
  gtcd_core u_core (
    .clk          (clk),
    .stage_en     (rdy[ST_OUT-1:0]),
    .gps_week     (in_gps_week),
    .tow_ms       (in_tow_ms),
    .leap_seconds (leap_r),
    .res          (res)
  );

  // ---- output stage: day, month and year from the month count f
  // f runs 4..15; f of 14 and 15 are January and February of the next year
  always_comb begin
    day_full = res.g - G_W'(month_base(res.f));
    day_nxt  = day_full[DAY_W-1:0];
    if (res.f < 4'd14) begin
      month_nxt = res.f - 4'd1;
      year_nxt  = YEAR_W'(res.dy - DY_W'(YEAR_OFFSET + 1));
    end else begin
      month_nxt = res.f - 4'd13;
      year_nxt  = YEAR_W'(res.dy - DY_W'(YEAR_OFFSET));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= res.hour;
      minute_r <= res.minute;
      milli_r  <= res.milli;
    end
  end

  assign out_valid           = vld_r[ST_OUT];
  assign out_year            = year_r;
  assign out_month           = month_r;
  assign out_day             = day_r;
  assign out_hour            = hour_r;
  assign out_minute          = minute_r;
  assign out_milli_of_minute = milli_r;

  // ---- assertions
  `GTCD_ASSERT_NOW(a_stall_full, in_stall, &vld_r, "input stalled with a free stage")
  `GTCD_ASSERT_NXT(a_stage_hold, vld_r[0] && !rdy[1], vld_r[0], "stage A word lost")
  `GTCD_ASSERT_NOW(a_month_rng, out_valid, out_month >= 4'd1 && out_month <= 4'd12, "bad month")
  `GTCD_ASSERT_NOW(a_day_rng, out_valid, out_day != 5'd0, "day of month is zero")
  `GTCD_ASSERT_NOW(a_time_rng, out_valid, out_hour < 5'd24 && out_minute < 6'd60 && out_milli_of_minute < 16'd60000, "time of day out of range")

endmodule
